FILE: hdl/nrmc_pkg.sv
// Package for the RMC sentence parser: sizes, character codes, result codes,
// the queue entry type and small lookup functions.
// Depends on nothing; every other file but nrmc_if.sv imports it.
`default_nettype none

package nrmc_pkg;

   localparam int FRAC_DIGITS = 5;
   localparam int TIME_CHARS  = 8;
   localparam int DATE_CHARS  = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int FRAC3       = (FRAC_DIGITS < 3) ? FRAC_DIGITS : 3;

   localparam logic [1:0] RES_OK         = 2'd0;
   localparam logic [1:0] RES_BAD_HEADER = 2'd1;
   localparam logic [1:0] RES_FEW_FIELDS = 2'd2;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_W      = 8'h57;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic [16:0] LAT_INT_CAP   = 17'd9999;
   localparam logic [16:0] OTHER_INT_CAP = 17'd99999;
   localparam logic [3:0]  FIELDS_NEEDED = 4'd11;
   localparam logic [3:0]  FIELD_MAX     = 4'd15;

   typedef struct packed {
      logic [1:0]      code;
      logic [63:0]     time_text;
      logic [47:0]     date_text;
      logic [3:0][7:0] letters;
   } snap_type;

   typedef struct packed {
      logic        conv;
      logic        emit;
      logic [2:0]  slot;
      logic [16:0] ival;
      logic [23:0] fd;
      logic [2:0]  fc;
      logic [9:0]  f3;
      snap_type    snap;
   } entry_type;

   function automatic logic [23:0] pow10(input logic [2:0] k);
      logic [23:0] v;
      case (k)
         3'd0: v = 24'd1;
         3'd1: v = 24'd10;
         3'd2: v = 24'd100;
         3'd3: v = 24'd1000;
         3'd4: v = 24'd10000;
         3'd5: v = 24'd100000;
         3'd6: v = 24'd1000000;
         default: v = 24'd10000000;
      endcase
      return v;
   endfunction

   // Expected header byte; position two also admits 'N'.
   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] v;
      case (pos)
         3'd0: v = CH_DOLLAR;
         3'd1: v = CH_G;
         3'd2: v = CH_P;
         3'd3: v = CH_R;
         3'd4: v = CH_M;
         default: v = CH_C;
      endcase
      return v;
   endfunction

   // {hit, index} of the letter capture for a field number.
   function automatic logic [2:0] letter_slot(input logic [3:0] n);
      logic [2:0] v;
      unique case (n)
         4'd2:  v = 3'b100;
         4'd4:  v = 3'b101;
         4'd6:  v = 3'b110;
         4'd11: v = 3'b111;
         default: v = 3'b000;
      endcase
      return v;
   endfunction

   // {hit, index} of the numeric capture for a field number.
   function automatic logic [3:0] number_slot(input logic [3:0] n);
      logic [3:0] v;
      unique case (n)
         4'd3:  v = 4'b1000;
         4'd5:  v = 4'b1001;
         4'd7:  v = 4'b1010;
         4'd8:  v = 4'b1011;
         4'd10: v = 4'b1100;
         default: v = 4'b0000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/nrmc_if.sv
// Channel interfaces of the RMC sentence parser: byte requests in, results out.
// Depends on nothing.
`default_nettype none

interface nrmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_byte;
   modport source (output valid, char_byte, last_byte, input ready);
   modport sink (input valid, char_byte, last_byte, output ready);
endinterface

interface nrmc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_code;
   logic [63:0]        time_text;
   logic [7:0]         fix_status;
   logic signed [30:0] latitude_e7;
   logic [7:0]         lat_hemisphere;
   logic signed [34:0] longitude_e7;
   logic [7:0]         lon_hemisphere;
   logic [26:0]        speed_milliknots;
   logic [26:0]        course_millideg;
   logic [47:0]        date_text;
   logic signed [27:0] variation_millideg;
   logic [7:0]         variation_direction;
   modport source (output valid, result_code, time_text, fix_status, latitude_e7,
                   lat_hemisphere, longitude_e7, lon_hemisphere, speed_milliknots,
                   course_millideg, date_text, variation_millideg,
                   variation_direction, input ready);
   modport sink (input valid, result_code, time_text, fix_status, latitude_e7,
                 lat_hemisphere, longitude_e7, lon_hemisphere, speed_milliknots,
                 course_millideg, date_text, variation_millideg,
                 variation_direction, output ready);
endinterface

`default_nettype wire

FILE: hdl/nrmc_front.sv
// Front end: accepts sentence bytes, checks the header, splits fields and
// accumulates digits, and queues conversion and emit jobs. Uses nrmc_pkg.
`default_nettype none

module nrmc_front
   import nrmc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nrmc_req_if.sink   req_chan,
   input  wire logic  q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   logic [2:0]      pos_ff, pos_in;
   logic            hdr_ok_ff, hdr_ok_in;
   logic [3:0]      fnum_ff, fnum_in;
   logic            mark_ff, mark_in;
   logic            has_ff, has_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [16:0]     int_ff, int_in;
   logic [23:0]     frac_ff, frac_in;
   logic [2:0]      fc_ff, fc_in;
   logic [9:0]      f3_ff, f3_in;
   logic            point_ff, point_in;
   logic            stop_ff, stop_in;
   logic [63:0]     time_ff, time_in;
   logic [47:0]     date_ff, date_in;
   logic [3:0][7:0] let_ff, let_in;

   logic       accept;
   logic [7:0] c;
   logic       conv_hit;
   logic [2:0] ls;
   logic [3:0] ns;
   logic [3:0] digit;
   logic [20:0] wide_int;
   logic [16:0] cap;
   logic [1:0]  code;

   assign c        = req_chan.char_byte;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !q_full;
   assign ls       = letter_slot(fnum_ff);
   assign ns       = number_slot(fnum_ff);
   assign digit    = 4'(c - CH_ZERO);
   assign wide_int = 21'(int_ff) * 21'd10 + 21'(digit);
   assign cap      = (ns[2:0] == 3'd0) ? LAT_INT_CAP : OTHER_INT_CAP;

   always_comb begin
      pos_in = pos_ff;  hdr_ok_in = hdr_ok_ff;  fnum_in = fnum_ff;  mark_in = mark_ff;
      has_in = has_ff;  cnt_in = cnt_ff;  int_in = int_ff;  frac_in = frac_ff;
      fc_in = fc_ff;  f3_in = f3_ff;  point_in = point_ff;  stop_in = stop_ff;
      time_in = time_ff;  date_in = date_ff;  let_in = let_ff;
      conv_hit = 1'b0;

      if (pos_ff < 3'd6) begin
         if (pos_ff == 3'd2) begin
            if (c != CH_N && c != CH_P) hdr_ok_in = 1'b0;
         end else if (c != hdr_char(pos_ff)) begin
            hdr_ok_in = 1'b0;
         end
         pos_in = pos_ff + 3'd1;
      end

      if (!mark_ff) begin
         if (c == CH_STAR || c == CH_NUL) begin
            mark_in = 1'b1;
         end else if (c == CH_COMMA) begin
            conv_hit = ns[3];
            if (fnum_ff < FIELD_MAX) fnum_in = fnum_ff + 4'd1;
            has_in = 1'b0;  cnt_in = '0;  int_in = '0;  frac_in = '0;
            fc_in = '0;  f3_in = '0;  point_in = 1'b0;  stop_in = 1'b0;
         end else begin
            if (!has_ff && ls[2]) let_in[ls[1:0]] = c;
            has_in = 1'b1;
            if (fnum_ff == 4'd1 && cnt_ff < 4'(TIME_CHARS))
               time_in[{cnt_ff[2:0], 3'b000} +: 8] = c;
            if (fnum_ff == 4'd9 && cnt_ff < 4'(DATE_CHARS))
               date_in[{cnt_ff[2:0], 3'b000} +: 8] = c;
            if (ns[3] && !stop_ff) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  if (!point_ff) begin
                     int_in = (wide_int > 21'(cap)) ? cap : wide_int[16:0];
                  end else if (fc_ff < 3'(FRAC_DIGITS)) begin
                     frac_in = 24'(frac_ff * 24'd10 + 24'(digit));
                     if (fc_ff < 3'(FRAC3)) f3_in = 10'(f3_ff * 10'd10 + 10'(digit));
                     fc_in = fc_ff + 3'd1;
                  end
               end else if (c == CH_POINT && !point_ff) begin
                  point_in = 1'b1;
               end else begin
                  stop_in = 1'b1;
               end
            end
            if (cnt_ff < FIELD_MAX) cnt_in = cnt_ff + 4'd1;
         end
      end

      if (pos_in < 3'd6 || !hdr_ok_in) code = RES_BAD_HEADER;
      else if (fnum_in < FIELDS_NEEDED) code = RES_FEW_FIELDS;
      else code = RES_OK;
   end

   always_comb begin
      q_push              = accept && (conv_hit || req_chan.last_byte);
      q_entry.conv        = conv_hit;
      q_entry.emit        = req_chan.last_byte;
      q_entry.slot        = ns[2:0];
      q_entry.ival        = int_ff;
      q_entry.fd          = frac_ff;
      q_entry.fc          = fc_ff;
      q_entry.f3          = f3_ff;
      q_entry.snap.code      = code;
      q_entry.snap.time_text = time_in;
      q_entry.snap.date_text = date_in;
      q_entry.snap.letters   = let_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.last_byte)) begin
         pos_ff <= '0;  hdr_ok_ff <= 1'b1;  fnum_ff <= '0;  mark_ff <= 1'b0;
         has_ff <= 1'b0;  cnt_ff <= '0;  int_ff <= '0;  frac_ff <= '0;
         fc_ff <= '0;  f3_ff <= '0;  point_ff <= 1'b0;  stop_ff <= 1'b0;
         time_ff <= '0;  date_ff <= '0;  let_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;  hdr_ok_ff <= hdr_ok_in;  fnum_ff <= fnum_in;
         mark_ff <= mark_in;  has_ff <= has_in;  cnt_ff <= cnt_in;  int_ff <= int_in;
         frac_ff <= frac_in;  fc_ff <= fc_in;  f3_ff <= f3_in;  point_ff <= point_in;
         stop_ff <= stop_in;  time_ff <= time_in;  date_ff <= date_in;  let_ff <= let_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/nrmc_queue.sv
// Short job queue between the front and back ends of the RMC parser.
// Uses nrmc_pkg for the entry type and depth.
`default_nettype none

module nrmc_queue
   import nrmc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push && !full) slots_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;  rd_ff <= '0;  count_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(do_pop);
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue pushed while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue pop lost");

endmodule

`default_nettype wire

FILE: hdl/nrmc_back.sv
// Back end: pipelined fixed-point conversion of numeric fields, capture
// storage and result assembly with an output register. Uses nrmc_pkg.
`default_nettype none

module nrmc_back
   import nrmc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   nrmc_rsp_if.source rsp_chan
);

   localparam int NSTAGE = 6;
   localparam logic [17:0] M100 = 18'd167773;     // ceil(2^24 / 100)
   localparam logic [28:0] M15  = 29'd286331154;  // ceil(2^32 / 15)

   typedef struct packed {
      entry_type   ent;
      logic [10:0] qa;
      logic [23:0] fsc;
      logic [26:0] other;
      logic [9:0]  deg;
      logic [29:0] mins;
      logic [29:0] nval;
      logic [33:0] degp;
      logic [56:0] prod;
      logic [33:0] val;
   } stage_type;

   stage_type       st_ff [NSTAGE];
   stage_type       st_in [NSTAGE];
   logic [NSTAGE-1:0] vld_ff;
   logic [4:0][33:0] num_ff, num_in;
   logic            stall;
   logic            out_valid_ff;
   stage_type       fin;

   logic [16:0] rem100;
   logic [27:0] x15;
   logic [24:0] q15;
   logic [4:0]  rem15;
   logic [2:0]  f3_exp;

   assign fin   = st_ff[NSTAGE-1];
   assign stall = vld_ff[NSTAGE-1] && fin.ent.emit && out_valid_ff && !rsp_chan.ready;
   assign pop   = !stall;
   assign rsp_chan.valid = out_valid_ff;

   always_comb begin
      st_in[0] = '0;
      st_in[0].ent = head_entry;

      // Stage A: quotient estimate by 100, fraction scaling, plain fields.
      st_in[1] = st_ff[0];
      st_in[1].qa = 11'(({18'b0, st_ff[0].ent.ival} * {18'b0, M100}) >> 24);
      st_in[1].fsc = 24'(st_ff[0].ent.fd *
                         pow10(3'(FRAC_DIGITS) - st_ff[0].ent.fc));
      f3_exp = (st_ff[0].ent.fc < 3'(FRAC3)) ? 3'd3 - st_ff[0].ent.fc : 3'd3 - 3'(FRAC3);
      st_in[1].other = 27'(27'(st_ff[0].ent.ival) * 27'd1000 +
                           27'(st_ff[0].ent.f3) * 27'(pow10(f3_exp)));

      // Stage B: exact degrees and minutes scaled to the fraction digits.
      st_in[2] = st_ff[1];
      rem100 = 17'(st_ff[1].ent.ival - 17'(st_ff[1].qa) * 17'd100);
      if (rem100 >= 17'd100) begin
         st_in[2].deg = 10'(st_ff[1].qa + 11'd1);
         rem100 = rem100 - 17'd100;
      end else begin
         st_in[2].deg = st_ff[1].qa[9:0];
      end
      st_in[2].mins = 30'(30'(rem100) * 30'(pow10(3'(FRAC_DIGITS))) + 30'(st_ff[1].fsc));

      // Stage C: minutes in units of 1e-7, degree part scaled.
      st_in[3] = st_ff[2];
      st_in[3].nval = 30'(st_ff[2].mins * 30'(pow10(3'(7 - FRAC_DIGITS))));
      st_in[3].degp = 34'(st_ff[2].deg) * 34'd10000000;

      // Stage D: divide by 60 as a shift by two and a reciprocal of 15.
      st_in[4] = st_ff[3];
      st_in[4].prod = {29'b0, st_ff[3].nval[29:2]} * {28'b0, M15};

      // Stage E: correct the quotient and pick the field value.
      st_in[5] = st_ff[4];
      x15   = st_ff[4].nval[29:2];
      q15   = st_ff[4].prod[56:32];
      rem15 = 5'(x15 - 28'(q15) * 28'd15);
      if (rem15 >= 5'd15) q15 = q15 + 25'd1;
      if (st_ff[4].ent.slot <= 3'd1) st_in[5].val = st_ff[4].degp + 34'(q15);
      else st_in[5].val = 34'(st_ff[4].other);
   end

   always_comb begin
      num_in = num_ff;
      if (vld_ff[NSTAGE-1] && fin.ent.conv) num_in[fin.ent.slot] = fin.val;
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         for (int k = 0; k < NSTAGE; k++) st_ff[k] <= st_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else if (!stall && vld_ff[NSTAGE-1]) begin
         if (fin.ent.emit) num_ff <= '0;
         else num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall && vld_ff[NSTAGE-1] && fin.ent.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall && vld_ff[NSTAGE-1] && fin.ent.emit) begin
         rsp_chan.result_code <= fin.ent.snap.code;
         if (fin.ent.snap.code == RES_OK) begin
            rsp_chan.time_text      <= fin.ent.snap.time_text;
            rsp_chan.fix_status     <= fin.ent.snap.letters[0];
            rsp_chan.latitude_e7    <= (fin.ent.snap.letters[1] == CH_S) ?
                                       -num_in[0][30:0] : num_in[0][30:0];
            rsp_chan.lat_hemisphere <= fin.ent.snap.letters[1];
            rsp_chan.longitude_e7   <= (fin.ent.snap.letters[2] == CH_W) ?
                                       -{1'b0, num_in[1]} : {1'b0, num_in[1]};
            rsp_chan.lon_hemisphere <= fin.ent.snap.letters[2];
            rsp_chan.speed_milliknots <= num_in[2][26:0];
            rsp_chan.course_millideg  <= num_in[3][26:0];
            rsp_chan.date_text        <= fin.ent.snap.date_text;
            rsp_chan.variation_millideg <= (fin.ent.snap.letters[3] == CH_W) ?
                                           -num_in[4][27:0] : num_in[4][27:0];
            rsp_chan.variation_direction <= fin.ent.snap.letters[3];
         end else begin
            rsp_chan.time_text <= '0;  rsp_chan.fix_status <= '0;
            rsp_chan.latitude_e7 <= '0;  rsp_chan.lat_hemisphere <= '0;
            rsp_chan.longitude_e7 <= '0;  rsp_chan.lon_hemisphere <= '0;
            rsp_chan.speed_milliknots <= '0;  rsp_chan.course_millideg <= '0;
            rsp_chan.date_text <= '0;  rsp_chan.variation_millideg <= '0;
            rsp_chan.variation_direction <= '0;
         end
      end
   end

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> out_valid_ff)
      else $error("result dropped while stalled");
   a_stall_only_emit: assert property (@(posedge clock) disable iff (reset)
      stall |-> (vld_ff[NSTAGE-1] && out_valid_ff))
      else $error("pipeline stalled without a pending result");
   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      stall |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

FILE: hdl/nmea_rmc_sentence_parser.sv
// Top level of the RMC sentence parser: front end, job queue and back end.
// Uses nrmc_pkg, nrmc_req_if, nrmc_rsp_if, nrmc_front, nrmc_queue, nrmc_back.
//
//   Channel    Direction  Carries
//   req_chan   in         char_byte, last_byte (one sentence byte per request)
//   rsp_chan   out        result_code and the eleven parsed fields
//
// One byte is accepted every cycle while the four-entry job queue has room.
// A result is offered once its last byte has passed through the job queue, the
// six pipeline stages, the first of which takes the queue head, and the output
// register. Reset clears all control state at once.
// A stalled result channel freezes the conversion stages only when a result
// waits; bytes keep flowing until the queue fills.
`default_nettype none

module nmea_rmc_sentence_parser
   import nrmc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   nrmc_req_if.sink   req_chan,
   nrmc_rsp_if.source rsp_chan
);

   logic      q_push, q_full, q_pop, q_head_valid;
   entry_type q_entry, q_head;

   nrmc_front u_front (
      .clock, .reset, .req_chan,
      .q_full, .q_push, .q_entry
   );

   nrmc_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_entry(q_entry), .full(q_full),
      .pop(q_pop), .head_valid(q_head_valid), .head_entry(q_head)
   );

   nrmc_back u_back (
      .clock, .reset,
      .head_valid(q_head_valid), .head_entry(q_head), .pop(q_pop),
      .rsp_chan
   );

endmodule

`default_nettype wire

FILE: tb/nrmc_rmc_checker.sv
// Checker for the RMC sentence parser: watches both channels, predicts each result
// from the accepted sentence bytes and compares it field by field.
// Depends on nrmc_pkg and the channel interfaces in nrmc_if.sv.
`timescale 1ns / 100ps
`default_nettype none

module nrmc_rmc_checker
   import nrmc_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   nrmc_req_if.sink  req_mon,
   nrmc_rsp_if.sink  rsp_mon,
   output int        fail_count,
   output int        pending_results,
   output int        results_seen
);

   typedef struct packed {
      logic [1:0]         code;
      logic [63:0]        time_text;
      logic [7:0]         fix;
      logic signed [30:0] lat;
      logic [7:0]         lat_h;
      logic signed [34:0] lon;
      logic [7:0]         lon_h;
      logic [26:0]        speed;
      logic [26:0]        course;
      logic [47:0]        date_text;
      logic signed [27:0] var_md;
      logic [7:0]         var_h;
   } rmc_fix_type;

   rmc_fix_type parsed_fixes[$];

   // Parser state mirrored from the block's behavior.
   logic [2:0]  pos;
   logic        hdr_ok, chk_mark, has_chars, pt_seen, num_stop;
   logic [3:0]  fld, ccount;
   longint unsigned ival, fval;
   int          fcount;
   logic [63:0] tstore;
   logic [47:0] dstore;
   logic [7:0]  letters[4];
   longint unsigned nums[5];

   function automatic int letter_idx(input logic [3:0] n);
      case (n)
         4'd2: return 0;
         4'd4: return 1;
         4'd6: return 2;
         4'd11: return 3;
         default: return -1;
      endcase
   endfunction

   function automatic int number_idx(input logic [3:0] n);
      case (n)
         4'd3: return 0;
         4'd5: return 1;
         4'd7: return 2;
         4'd8: return 3;
         4'd10: return 4;
         default: return -1;
      endcase
   endfunction

   function automatic longint unsigned ten_to(input int k);
      longint unsigned v;
      v = 1;
      for (int i = 0; i < k; i++) v = v * 10;
      return v;
   endfunction

   task automatic clear_number();
      has_chars = 0; ccount = 0; ival = 0; fval = 0; fcount = 0;
      pt_seen = 0; num_stop = 0;
   endtask

   task automatic clear_sentence();
      pos = 0; hdr_ok = 1; fld = 0; chk_mark = 0; tstore = 0; dstore = 0;
      for (int k = 0; k < 4; k++) letters[k] = 0;
      for (int k = 0; k < 5; k++) nums[k] = 0;
      clear_number();
   endtask

   task automatic finish_field();
      int ns;
      longint unsigned scale, f, mins;
      ns = number_idx(fld);
      scale = ten_to(FRAC_DIGITS);
      if (ns < 0) return;
      f = fval * ten_to(FRAC_DIGITS - fcount);
      if (ns <= 1) begin
         mins = (ival % 100) * scale + f;
         nums[ns] = (ival / 100) * 10000000 + (mins * 10000000) / (60 * scale);
      end else begin
         nums[ns] = ival * 1000 + (f * 1000) / scale;
      end
   endtask

   task automatic absorb_char(input logic [7:0] c);
      int ls, ns;
      longint unsigned cap, v;
      ls = letter_idx(fld);
      ns = number_idx(fld);
      if (!has_chars && ls >= 0) letters[ls] = c;
      has_chars = 1;
      if (fld == 4'd1 && ccount < TIME_CHARS) tstore[8*ccount +: 8] = c;
      if (fld == 4'd9 && ccount < DATE_CHARS) dstore[8*ccount +: 8] = c;
      if (ns >= 0 && !num_stop) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            if (!pt_seen) begin
               cap = (ns == 0) ? 9999 : 99999;
               v = ival * 10 + (c - CH_ZERO);
               ival = (v > cap) ? cap : v;
            end else if (fcount < FRAC_DIGITS) begin
               fval = fval * 10 + (c - CH_ZERO);
               fcount++;
            end
         end else if (c == CH_POINT && !pt_seen) begin
            pt_seen = 1;
         end else begin
            num_stop = 1;
         end
      end
      if (ccount < FIELD_MAX) ccount = ccount + 1;
   endtask

   task automatic predict_byte(input logic [7:0] c, input logic last);
      rmc_fix_type r;
      if (pos < 6) begin
         if (pos == 2) begin
            if (c != CH_N && c != CH_P) hdr_ok = 0;
         end else if (c != hdr_char(pos)) begin
            hdr_ok = 0;
         end
         pos = pos + 1;
      end
      if (!chk_mark) begin
         if (c == CH_STAR || c == CH_NUL) begin
            chk_mark = 1;
         end else if (c == CH_COMMA) begin
            finish_field();
            if (fld < FIELD_MAX) fld = fld + 1;
            clear_number();
         end else begin
            absorb_char(c);
         end
      end
      if (!last) return;
      r = '0;
      if (pos < 6 || !hdr_ok) r.code = RES_BAD_HEADER;
      else if (fld < FIELDS_NEEDED) r.code = RES_FEW_FIELDS;
      else r.code = RES_OK;
      if (r.code == RES_OK) begin
         r.time_text = tstore;
         r.fix = letters[0];
         r.lat = (letters[1] == CH_S) ? -nums[0] : nums[0];
         r.lat_h = letters[1];
         r.lon = (letters[2] == CH_W) ? -nums[1] : nums[1];
         r.lon_h = letters[2];
         r.speed = nums[2];
         r.course = nums[3];
         r.date_text = dstore;
         r.var_md = (letters[3] == CH_W) ? -nums[4] : nums[4];
         r.var_h = letters[3];
      end
      parsed_fixes.push_back(r);
      clear_sentence();
   endtask

   rmc_fix_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         clear_sentence();
         parsed_fixes.delete();
         fail_count <= 0;
         results_seen <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_byte(req_mon.char_byte, req_mon.last_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.result_code, rsp_mon.time_text, rsp_mon.fix_status,
                    rsp_mon.latitude_e7, rsp_mon.lat_hemisphere, rsp_mon.longitude_e7,
                    rsp_mon.lon_hemisphere, rsp_mon.speed_milliknots,
                    rsp_mon.course_millideg, rsp_mon.date_text,
                    rsp_mon.variation_millideg, rsp_mon.variation_direction};
            results_seen <= results_seen + 1;
            if (parsed_fixes.size() == 0) begin
               if (fail_count < 10) $display("unexpected result: %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = parsed_fixes.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("result mismatch at %0t", $realtime);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_results = parsed_fixes.size();
   end

endmodule

`default_nettype wire

FILE: tb/nmea_rmc_sentence_parser_tb.sv
// Testbench top for the RMC sentence parser: clock, reset, sentence stimulus with
// random gaps and result-side stalls, and the verdict.
// Depends on nrmc_pkg, nrmc_if.sv, the parser RTL and nrmc_rmc_checker.
`timescale 1ns / 100ps
`default_nettype none

module nmea_rmc_sentence_parser_tb;
   import nrmc_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_results, results_seen;
   int   bytes_sent, sentences_sent;
   logic long_hold;

   nrmc_req_if req_chan ();
   nrmc_rsp_if rsp_chan ();

   nmea_rmc_sentence_parser u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   nrmc_rmc_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending_results(pending_results),
      .results_seen(results_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   byte unsigned sentence[$];

   // Send one byte as a request; returns once it has been accepted.
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.char_byte <= c;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic sentence_done();
      sentences_sent++;
      sentence.delete();
   endtask

   task automatic send_sentence();
      for (int i = 0; i < sentence.size(); i++)
         send_byte(sentence[i], i == sentence.size() - 1);
      sentence_done();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) sentence.push_back(s[i]);
   endtask

   function automatic string rand_digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'(8'h30 + $urandom_range(0, 9)))};
      return s;
   endfunction

   // A numeric field body: mostly well-formed, sometimes odd.
   function automatic string rand_number(input int ip);
      string s;
      int k;
      k = $urandom_range(0, 9);
      s = rand_digits($urandom_range(0, ip));
      if (k < 7) s = {s, ".", rand_digits($urandom_range(0, 8))};
      else if (k == 7) s = {s, ".", rand_digits(2), ".", rand_digits(2)};
      else if (k == 8) s = {"-", s};
      else s = {s, "e", rand_digits(1)};
      if ($urandom_range(0, 15) == 0) s = "";
      return s;
   endfunction

   function automatic string pick(input string a, input string b);
      return $urandom_range(0, 1) ? a : b;
   endfunction

   task automatic build_random_sentence();
      int kind, nf;
      string f[13];
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // Pure noise bytes.
         repeat ($urandom_range(1, 30)) sentence.push_back(8'($urandom_range(0, 255)));
         return;
      end
      put_text(pick("$GPRMC", "$GNRMC"));
      if (kind == 1) sentence[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
      f[1] = rand_digits($urandom_range(0, 10));
      f[2] = pick("A", "V");
      f[3] = rand_number(5);
      f[4] = pick("N", "S");
      f[5] = rand_number(6);
      f[6] = pick("E", "W");
      f[7] = rand_number(6);
      f[8] = rand_number(6);
      f[9] = rand_digits($urandom_range(0, 8));
      f[10] = rand_number(6);
      f[11] = pick("E", "W");
      f[12] = pick("A", "D");
      for (int i = 1; i <= 12; i++)
         if ($urandom_range(0, 11) == 0) f[i] = "";
      nf = (kind == 2) ? $urandom_range(0, 12) : 12;
      if (kind == 3) nf = 12 + $urandom_range(1, 3);
      for (int i = 1; i <= nf; i++) begin
         put_text(",");
         if (i <= 12) put_text(f[i]);
         else put_text(rand_digits(2));
      end
      if (kind == 4) begin
         put_text(pick("*", ","));
         repeat ($urandom_range(0, 4)) sentence.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 5) begin
         sentence.push_back(8'h00);
         put_text("ab");
      end else if ($urandom_range(0, 1)) begin
         put_text("*");
         put_text(rand_digits(2));
      end
   endtask

   initial begin
      string directed[$];
      req_chan.valid = 0;
      req_chan.char_byte = 0;
      req_chan.last_byte = 0;
      bytes_sent = 0;
      sentences_sent = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      directed = '{
         "$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
         "$GNRMC,235959.999,V,9999.99999,S,18059.99999,W,99999.99999,99999.9,311299,99999.999,W,A",
         "$GNRMC,,,,,,,,,,,,",
         "$GPRMC,1,A,.5,N,.,E,1.2.3,-5,010100,1e5,E,D*",
         "$GPRMC,12345678901,A,99999999.9999999,S,9999999.123,W,5x,7 ,99123456,3,E,N,extra,x",
         "$GPXMC,1,A,1,N,1,E,1,1,1,1,E,A",
         "$GNRM",
         "$",
         "$GPRMC,1,A,1*,,,,,,,,,,,,",
         "$GPRMC,1,A,1,N,1,E",
         "$GQRMC,,,,,,,,,,,,",
         "#GPRMC,,,,,,,,,,,,",
         "$GPRMC,1,A,4807.038,N,01131.000,E,1,2,3,4,W"
      };
      foreach (directed[i]) begin
         put_text(directed[i]);
         send_sentence();
      end
      // A zero byte and the top byte value inside fields.
      put_text("$GPRMC,");
      sentence.push_back(8'hFF);
      put_text(",A,1,N,1,E,1,1,");
      sentence.push_back(8'h80);
      put_text(",1,W,A");
      sentence.push_back(8'h00);
      put_text(",,");
      send_sentence();

      while (bytes_sent < 1750) begin
         build_random_sentence();
         send_sentence();
      end
      req_chan.valid <= 0;
      req_chan.last_byte <= 0;

      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d sentences (%0d bytes); %0d results checked, with stalls.",
               sentences_sent, bytes_sent, results_seen);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side: a random wait before each result, plus one long hold-off so
   // the queue fills and the input stalls.
   initial begin
      int wait_cycles;
      long_hold = 0;
      rsp_chan.ready = 0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (!long_hold && bytes_sent > 600) begin
            long_hold = 1;
            rsp_chan.ready <= 0;
            repeat (300) @(negedge clock);
         end
         wait_cycles = $urandom_range(0, 3);
         if (wait_cycles > 0) begin
            rsp_chan.ready <= 0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_chan.ready <= 1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
